/* rtl/ptrmx_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the persistent trie range maximum XOR block.
// Used by ptrmx_ctrl, ptrmx_dp and persistent_trie_range_max_xor; no dependencies.
package ptrmx_pkg;

  localparam int KEY_BITS_DEF     = 24;
  localparam int MAX_VERSIONS_DEF = 1024;

  localparam int VALUE_W  = 24;
  localparam int BOUND_W  = 11;
  localparam int RESULT_W = 24;

  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  typedef enum logic [1:0] {
    ST_QUERY_OK  = 2'd0,
    ST_APPENDED  = 2'd1,
    ST_POOL_FULL = 2'd2,
    ST_BAD_RANGE = 2'd3
  } status_t;

  typedef struct packed {
    logic               op;
    logic [VALUE_W-1:0] value;
    logic [BOUND_W-1:0] left;
    logic [BOUND_W-1:0] right;
  } req_t;

  typedef struct packed {
    logic [RESULT_W-1:0] result;
    status_t             status;
  } rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_A_RD,
    S_A_WR,
    S_A_LEAF,
    S_Q_ROOT,
    S_Q_NODE,
    S_Q_RD,
    S_Q_DEC,
    S_DONE
  } state_t;

  typedef struct packed {
    logic    capture;
    logic    app_init;
    logic    q_init;
    logic    app_rd;
    logic    app_step;
    logic    app_leaf;
    logic    q_root;
    logic    q_node;
    logic    q_rd;
    logic    q_dec;
    logic    out_load;
    status_t out_status;
  } dp_cmd_t;

  typedef struct packed {
    logic is_query;
    logic pool_full;
    logic bad_range;
    logic level_zero;
  } dp_stat_t;

endpackage

/* rtl/ptrmx_ctrl.sv */
`timescale 1ns / 1ps
// Controller state machine: sequences appends and queries over the trie levels.
// Depends on ptrmx_pkg for the state, command and status types.
module ptrmx_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  input  ptrmx_pkg::dp_stat_t stat,
  output ptrmx_pkg::dp_cmd_t  cmd
);
  import ptrmx_pkg::*;

  state_t  state, state_next;
  status_t fin_status, fin_status_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      fin_status <= ST_QUERY_OK;
      rsp_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      fin_status <= fin_status_next;
      if (cmd.out_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    cmd             = '0;
    cmd.out_status  = fin_status;
    state_next      = state;
    fin_status_next = fin_status;
    req_ready       = (state == S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_CHECK;
        end
      end
      S_CHECK: begin
        priority if (stat.is_query && stat.bad_range) begin
          fin_status_next = ST_BAD_RANGE;
          state_next      = S_DONE;
        end else if (stat.is_query) begin
          cmd.q_init = 1'b1;
          state_next = S_Q_ROOT;
        end else if (stat.pool_full) begin
          fin_status_next = ST_POOL_FULL;
          state_next      = S_DONE;
        end else begin
          cmd.app_init = 1'b1;
          state_next   = S_A_RD;
        end
      end
      S_A_RD: begin
        cmd.app_rd = 1'b1;
        state_next = S_A_WR;
      end
      S_A_WR: begin
        cmd.app_step = 1'b1;
        state_next   = stat.level_zero ? S_A_LEAF : S_A_RD;
      end
      S_A_LEAF: begin
        cmd.app_leaf    = 1'b1;
        fin_status_next = ST_APPENDED;
        state_next      = S_DONE;
      end
      S_Q_ROOT: begin
        cmd.q_root = 1'b1;
        state_next = S_Q_NODE;
      end
      S_Q_NODE: begin
        cmd.q_node = 1'b1;
        state_next = S_Q_RD;
      end
      S_Q_RD: begin
        cmd.q_rd   = 1'b1;
        state_next = S_Q_DEC;
      end
      S_Q_DEC: begin
        cmd.q_dec = 1'b1;
        if (stat.level_zero) begin
          fin_status_next = ST_QUERY_OK;
          state_next      = S_DONE;
        end else begin
          state_next = S_Q_RD;
        end
      end
      S_DONE: begin
        // The output register frees up in the same cycle its beat is taken.
        if (!rsp_valid || rsp_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!rsp_valid || rsp_ready))
    else $error("result loaded over a beat not yet taken");

  a_accept_check: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> (state == S_CHECK))
    else $error("accepted beat did not start a check");

  a_done_out: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && rsp_ready) |=> (state == S_IDLE && rsp_valid))
    else $error("finished item did not reach the output");

endmodule

/* rtl/ptrmx_dp.sv */
`timescale 1ns / 1ps
// Datapath: node pool memories, version root table, running prefix and walk registers.
// Depends on ptrmx_pkg; driven by ptrmx_ctrl through dp_cmd_t.
module ptrmx_dp #(
  parameter int KEY_BITS     = ptrmx_pkg::KEY_BITS_DEF,
  parameter int MAX_VERSIONS = ptrmx_pkg::MAX_VERSIONS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  ptrmx_pkg::req_t     req,
  input  ptrmx_pkg::dp_cmd_t  cmd,
  output ptrmx_pkg::dp_stat_t stat,
  output ptrmx_pkg::rsp_t     rsp
);
  import ptrmx_pkg::*;

  localparam int NODE_POOL = (MAX_VERSIONS + 2) * (KEY_BITS + 1);
  localparam int NODE_W    = $clog2(NODE_POOL);
  localparam int VER_W     = $clog2(MAX_VERSIONS + 1);
  localparam int LVL_W     = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;
  localparam int CMP_W     = ((VER_W > BOUND_W) ? VER_W : BOUND_W) + 1;
  localparam int WIDE_W    = (KEY_BITS > VALUE_W) ? KEY_BITS : VALUE_W;

  localparam logic [NODE_W-1:0] ROOT_ZERO  = NODE_W'(1);
  localparam logic [NODE_W-1:0] PATH_LAST  = NODE_W'(KEY_BITS + 1);
  localparam logic [NODE_W-1:0] FIRST_FREE = NODE_W'(KEY_BITS + 2);
  localparam logic [LVL_W-1:0]  KEY_TOP    = LVL_W'(KEY_BITS - 1);
  localparam logic [VER_W-1:0]  VER_MAX    = VER_W'(MAX_VERSIONS);

  // Node pool and version roots. Nodes 0 (null) through PATH_LAST (the path of
  // version zero) are never written; their contents are decoded from the address.
  logic [NODE_W-1:0] child_zero   [NODE_POOL];
  logic [NODE_W-1:0] child_one    [NODE_POOL];
  logic [VER_W-1:0]  node_version [NODE_POOL];
  logic [NODE_W-1:0] version_root [MAX_VERSIONS + 1];

  req_t              req_q;
  logic [KEY_BITS-1:0] prefix;
  logic [KEY_BITS-1:0] key;
  logic [KEY_BITS-1:0] best;
  logic [LVL_W-1:0]  level;
  logic [VER_W-1:0]  count;
  logic [VER_W-1:0]  low;
  logic [NODE_W-1:0] next_free;
  logic [NODE_W-1:0] last_root;
  logic [NODE_W-1:0] new_root;
  logic [NODE_W-1:0] cur;
  logic [NODE_W-1:0] prev;
  logic [NODE_W-1:0] c0;
  logic [NODE_W-1:0] c1;
  rsp_t              rsp_q;

  logic [NODE_W-1:0] rd_a_addr, rd_b_addr, rda_addr, rdb_addr;
  logic [NODE_W-1:0] rda_c0, rda_c1, rdb_c0, rdb_c1;
  logic [VER_W-1:0]  rda_ver;
  logic [VER_W-1:0]  vr_addr, vr_addr_q;
  logic [NODE_W-1:0] vr_data;

  logic [NODE_W-1:0] a_c0, a_c1, b_c0, b_c1;
  logic [VER_W-1:0]  a_ver;
  logic              a_null;
  logic [NODE_W-1:0] root;

  logic              wr_en;
  logic [NODE_W-1:0] wr_addr, wr_c0, wr_c1;
  logic [VER_W-1:0]  wr_ver;
  logic [VER_W-1:0]  ver_new;

  logic [WIDE_W-1:0]   val_wide;
  logic [KEY_BITS-1:0] val_key;
  logic [KEY_BITS-1:0] prefix_new;
  logic [WIDE_W-1:0]   best_wide;
  logic [CMP_W-1:0]    l_ext, r_ext, l_m1, r_m1;
  logic                key_bit;
  logic                take;

  assign val_wide   = WIDE_W'(req_q.value);
  assign val_key    = val_wide[KEY_BITS-1:0];
  assign prefix_new = prefix ^ val_key;
  assign best_wide  = WIDE_W'(best);
  assign key_bit    = key[level];
  assign ver_new    = count + VER_W'(1);

  assign l_ext = CMP_W'(req_q.left);
  assign r_ext = CMP_W'(req_q.right);
  assign l_m1  = l_ext - CMP_W'(1);
  assign r_m1  = r_ext - CMP_W'(1);

  assign stat.is_query   = (req_q.op == OP_QUERY);
  assign stat.pool_full  = (count == VER_MAX);
  assign stat.bad_range  = (l_ext == '0) || (r_ext < l_ext) || (r_m1 > CMP_W'(count));
  assign stat.level_zero = (level == '0);

  assign vr_addr = r_m1[VER_W-1:0];
  assign root    = (vr_addr_q == '0) ? ROOT_ZERO : vr_data;
  assign a_null  = (rda_addr == '0);
  assign take    = !a_null && (a_ver >= low);

  // Read addresses for the two node ports.
  always_comb begin
    rd_a_addr = '0;
    rd_b_addr = '0;
    if (cmd.app_rd) begin
      rd_a_addr = prev;
    end else if (cmd.q_root) begin
      rd_a_addr = root;
    end else if (cmd.q_rd) begin
      rd_a_addr = key_bit ? c0 : c1;
      rd_b_addr = key_bit ? c1 : c0;
    end
  end

  // Fixed contents of the null node and the version-zero path.
  always_comb begin
    a_c0  = rda_c0;
    a_c1  = rda_c1;
    a_ver = rda_ver;
    if (rda_addr == '0 || rda_addr == PATH_LAST) begin
      a_c0  = '0;
      a_c1  = '0;
      a_ver = '0;
    end else if (rda_addr < PATH_LAST) begin
      a_c0  = rda_addr + NODE_W'(1);
      a_c1  = '0;
      a_ver = '0;
    end
    b_c0 = rdb_c0;
    b_c1 = rdb_c1;
    if (rdb_addr == '0 || rdb_addr == PATH_LAST) begin
      b_c0 = '0;
      b_c1 = '0;
    end else if (rdb_addr < PATH_LAST) begin
      b_c0 = rdb_addr + NODE_W'(1);
      b_c1 = '0;
    end
  end

  // Node writes: one inner node per level, then the leaf.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cur;
    wr_c0   = '0;
    wr_c1   = '0;
    wr_ver  = ver_new;
    if (cmd.app_step) begin
      wr_en = 1'b1;
      wr_c0 = key_bit ? a_c0 : next_free;
      wr_c1 = key_bit ? next_free : a_c1;
    end else if (cmd.app_leaf) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    rda_c0    <= child_zero[rd_a_addr];
    rda_c1    <= child_one[rd_a_addr];
    rda_ver   <= node_version[rd_a_addr];
    rdb_c0    <= child_zero[rd_b_addr];
    rdb_c1    <= child_one[rd_b_addr];
    rda_addr  <= rd_a_addr;
    rdb_addr  <= rd_b_addr;
    vr_data   <= version_root[vr_addr];
    vr_addr_q <= vr_addr;
    if (wr_en) begin
      child_zero[wr_addr]   <= wr_c0;
      child_one[wr_addr]    <= wr_c1;
      node_version[wr_addr] <= wr_ver;
    end
    if (cmd.app_init) begin
      version_root[ver_new] <= next_free;
    end
  end

  // Control state of the trie.
  always_ff @(posedge clk) begin
    if (rst) begin
      prefix    <= '0;
      count     <= '0;
      next_free <= FIRST_FREE;
      last_root <= ROOT_ZERO;
    end else begin
      if (cmd.app_init) begin
        prefix    <= prefix_new;
        next_free <= next_free + NODE_W'(1);
      end else if (cmd.app_step) begin
        next_free <= next_free + NODE_W'(1);
      end
      if (cmd.app_leaf) begin
        count     <= ver_new;
        last_root <= new_root;
      end
    end
  end

  // Walk registers and the output beat.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_q <= req;
    end
    if (cmd.app_init) begin
      key      <= prefix_new;
      new_root <= next_free;
      cur      <= next_free;
      prev     <= last_root;
      level    <= KEY_TOP;
    end
    if (cmd.q_init) begin
      key   <= prefix ^ val_key;
      best  <= '0;
      level <= KEY_TOP;
      low   <= l_m1[VER_W-1:0];
    end
    if (cmd.app_step) begin
      cur  <= next_free;
      prev <= key_bit ? a_c1 : a_c0;
      if (level != '0) begin
        level <= level - LVL_W'(1);
      end
    end
    if (cmd.q_node) begin
      c0 <= a_c0;
      c1 <= a_c1;
    end
    if (cmd.q_dec) begin
      if (take) begin
        best[level] <= 1'b1;
        c0          <= a_c0;
        c1          <= a_c1;
      end else begin
        c0 <= b_c0;
        c1 <= b_c1;
      end
      if (level != '0) begin
        level <= level - LVL_W'(1);
      end
    end
    if (cmd.out_load) begin
      rsp_q.status <= cmd.out_status;
      rsp_q.result <= (cmd.out_status == ST_QUERY_OK) ? best_wide[RESULT_W-1:0] : '0;
    end
  end

  assign rsp = rsp_q;

  a_wr_fresh: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (wr_addr > PATH_LAST))
    else $error("write into the null node or the version-zero path");

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= VER_MAX)
    else $error("version count beyond the pool");

  a_leaf_count: assert property (@(posedge clk) disable iff (rst)
    cmd.app_leaf |=> (count == $past(count) + VER_W'(1)))
    else $error("finished append did not advance the version count");

endmodule

/* rtl/persistent_trie_range_max_xor.sv */
`timescale 1ns / 1ps
// Persistent binary trie of running XOR prefixes with range maximum XOR queries.
// Appends and queries walk the trie one level at a time: each level is a node memory
// read, then a write (append) or a decide (query). Bad-range and full-pool items
// finish without a walk. One item is handled at a time.
// Synchronous reset restores version zero at once: the null node and the version-zero
// path are decoded from their addresses, so no memory clearing pass is needed.
module persistent_trie_range_max_xor #(
  parameter int KEY_BITS     = ptrmx_pkg::KEY_BITS_DEF,
  parameter int MAX_VERSIONS = ptrmx_pkg::MAX_VERSIONS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  ptrmx_pkg::req_t req,
  output logic            rsp_valid,
  input  logic            rsp_ready,
  output ptrmx_pkg::rsp_t rsp
);
  import ptrmx_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  ptrmx_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ptrmx_dp #(
    .KEY_BITS     (KEY_BITS),
    .MAX_VERSIONS (MAX_VERSIONS)
  ) u_dp (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .cmd  (cmd),
    .stat (stat),
    .rsp  (rsp)
  );

endmodule

/* sim/ptrmx_checker.sv */
`timescale 1ns / 1ps
// Checker for the persistent trie range maximum XOR block: predicts every reply and
// compares it with the block's response beats. Depends on ptrmx_pkg.
module ptrmx_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  input  logic              req_ready,
  input  ptrmx_pkg::req_t   req,
  input  logic              rsp_valid,
  input  logic              rsp_ready,
  input  ptrmx_pkg::rsp_t   rsp,
  output int                failures,
  output int                outstanding,
  output int                appends_seen,
  output int                drops_seen,
  output int                queries_seen,
  output int                bad_ranges_seen
);
  import ptrmx_pkg::*;

  localparam int DEPTH = MAX_VERSIONS_DEF;

  // Running XOR prefix of each version; version 0 holds zero.
  logic [VALUE_W-1:0] version_prefix [0:DEPTH];
  logic [VALUE_W-1:0] running_xor;
  int                 version_total;
  rsp_t               replies_due [$];
  int                 fail_tally;
  int                 status_tally [4];

  // Updates the version history and returns the reply the block owes for one beat.
  function automatic rsp_t trie_reply(input req_t item);
    rsp_t               reply;
    logic [VALUE_W-1:0] key;
    int                 lo;
    int                 hi;
    reply.result = '0;
    lo = int'(item.left);
    hi = int'(item.right);
    if (item.op == OP_APPEND) begin
      if (version_total >= DEPTH) begin
        reply.status = ST_POOL_FULL;
      end else begin
        running_xor = running_xor ^ item.value;
        version_total++;
        version_prefix[version_total] = running_xor;
        reply.status = ST_APPENDED;
      end
    end else if (lo == 0 || hi < lo || hi - 1 > version_total) begin
      reply.status = ST_BAD_RANGE;
    end else begin
      // The version stamps keep every prefix of the range reachable, so the greedy
      // walk finds the true maximum over versions lo-1 to hi-1.
      key = running_xor ^ item.value;
      for (int v = lo - 1; v <= hi - 1; v++) begin
        if ((version_prefix[v] ^ key) > reply.result) begin
          reply.result = version_prefix[v] ^ key;
        end
      end
      reply.status = ST_QUERY_OK;
    end
    return reply;
  endfunction

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      running_xor = '0;
      version_total = 0;
      version_prefix[0] = '0;
      replies_due.delete();
      fail_tally = 0;
      status_tally = '{default: 0};
    end else begin
      if (req_valid && req_ready) begin
        replies_due.push_back(trie_reply(req));
      end
      if (rsp_valid && rsp_ready) begin
        if (replies_due.size() == 0) begin
          $error("response beat with nothing owed: result %h, status %0d",
                 rsp.result, rsp.status);
          fail_tally++;
        end else begin
          want = replies_due.pop_front();
          status_tally[want.status]++;
          if (rsp.result !== want.result) begin
            $error("result: expected %h, got %h", want.result, rsp.result);
            fail_tally++;
          end
          if (rsp.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp.status);
            fail_tally++;
          end
        end
      end
    end
    failures        <= fail_tally;
    outstanding     <= replies_due.size();
    appends_seen    <= status_tally[ST_APPENDED];
    drops_seen      <= status_tally[ST_POOL_FULL];
    queries_seen    <= status_tally[ST_QUERY_OK];
    bad_ranges_seen <= status_tally[ST_BAD_RANGE];
  end

endmodule

/* sim/tb_persistent_trie_range_max_xor.sv */
`timescale 1ns / 1ps
// Testbench top for persistent_trie_range_max_xor: drives request beats, stalls the
// response side and gives the verdict. Depends on ptrmx_pkg and ptrmx_checker.
module tb_persistent_trie_range_max_xor;
  import ptrmx_pkg::*;

  localparam int QUIET_LIMIT = 4000;
  localparam int MAX_VER     = MAX_VERSIONS_DEF;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  logic steady = 1'b0;
  int   appended = 0;
  int   quiet = 0;

  int failures;
  int outstanding;
  int appends_seen;
  int drops_seen;
  int queries_seen;
  int bad_ranges_seen;

  persistent_trie_range_max_xor dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  ptrmx_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .req_valid       (req_valid),
    .req_ready       (req_ready),
    .req             (req),
    .rsp_valid       (rsp_valid),
    .rsp_ready       (rsp_ready),
    .rsp             (rsp),
    .failures        (failures),
    .outstanding     (outstanding),
    .appends_seen    (appends_seen),
    .drops_seen      (drops_seen),
    .queries_seen    (queries_seen),
    .bad_ranges_seen (bad_ranges_seen)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    rsp_ready <= steady || ($urandom_range(0, 99) >= 31);
  end

  always @(posedge clk) begin
    if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet == QUIET_LIMIT) begin
      $display("tb_persistent_trie_range_max_xor failed");
      $finish;
    end
  end

  // Values mix dense random words with sparse ones so prefixes share long paths.
  function automatic logic [VALUE_W-1:0] pick_value();
    unique case ($urandom_range(0, 3))
      0: return VALUE_W'($urandom_range(0, 15));
      1: return {VALUE_W{1'b1}} ^ VALUE_W'($urandom_range(0, 15));
      2: return VALUE_W'(1) << $urandom_range(0, VALUE_W - 1);
      default: return VALUE_W'($urandom);
    endcase
  endfunction

  // Bounds of an append are ignored by the block, so they carry random bits.
  function automatic req_t append_beat(input logic [VALUE_W-1:0] x);
    req_t b;
    b.op = OP_APPEND;
    b.value = x;
    b.left = BOUND_W'($urandom);
    b.right = BOUND_W'($urandom);
    return b;
  endfunction

  function automatic req_t query_beat(input logic [VALUE_W-1:0] x, input int l, input int r);
    req_t b;
    b.op = OP_QUERY;
    b.value = x;
    b.left = BOUND_W'(l);
    b.right = BOUND_W'(r);
    return b;
  endfunction

  function automatic req_t fair_query();
    int l;
    l = $urandom_range(1, appended + 1);
    return query_beat(pick_value(), l, $urandom_range(l, appended + 1));
  endfunction

  function automatic req_t random_beat();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      return append_beat(pick_value());
    end else if (pick < 90) begin
      return fair_query();
    end
    // Noise: a query with value and bounds fully random, mostly giving bad ranges.
    return req_t'({1'b1, VALUE_W'($urandom), BOUND_W'($urandom), BOUND_W'($urandom)});
  endfunction

  task automatic send(input req_t item);
    while (!steady && $urandom_range(0, 99) < 31) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= item;
    @(posedge clk);
    while (!req_ready) begin
      @(posedge clk);
    end
    if (item.op == OP_APPEND && appended < MAX_VER) begin
      appended++;
    end
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) begin
      @(posedge clk);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Version zero alone, then bad ranges of every kind.
    send(query_beat('0, 1, 1));
    send(query_beat('1, 1, 1));
    send(query_beat(24'h5A5A5A, 0, 1));
    send(query_beat('0, 1, 2));
    send(query_beat('0, 2, 1));
    send(query_beat('1, 0, 0));
    send(query_beat('1, 2047, 2047));
    send(query_beat('0, 1, 1025));
    send(append_beat('1));
    send(append_beat('0));
    send(append_beat(24'hA5A5A5));
    send(append_beat(24'h000001));
    send(append_beat(24'h800000));
    send(query_beat('0, 1, 6));
    send(query_beat('1, 6, 6));
    send(query_beat(24'h123456, 2, 4));
    send(query_beat('0, 1, 7));
    send(query_beat('1, 3, 3));

    repeat (300) send(random_beat());

    // Hold the sender until the block has answered everything.
    drain();

    // Grow the trie back to back, mostly appends with some queries.
    steady <= 1'b1;
    repeat (400) begin
      if ($urandom_range(0, 99) < 20) begin
        send(fair_query());
      end else begin
        send(append_beat(pick_value()));
      end
    end
    steady <= 1'b0;

    // The widest range, the newest version alone, one past it, and two appends.
    send(query_beat('0, 1, appended + 1));
    send(query_beat('1, appended + 1, appended + 1));
    send(query_beat(24'h3C3C3C, 1, appended + 2));
    send(append_beat('1));
    send(append_beat('0));

    repeat (75) send(random_beat());

    drain();
    repeat (64) @(posedge clk);

    $display("Run covered %0d appends, %0d dropped on a full pool, %0d range queries",
             appends_seen, drops_seen, queries_seen);
    $display("and %0d queries with bad ranges.", bad_ranges_seen);
    if (failures == 0) begin
      $display("tb_persistent_trie_range_max_xor passed");
    end else begin
      $display("tb_persistent_trie_range_max_xor failed");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/ptrmx_pkg.sv
rtl/ptrmx_ctrl.sv
rtl/ptrmx_dp.sv
rtl/persistent_trie_range_max_xor.sv
sim/ptrmx_checker.sv
sim/tb_persistent_trie_range_max_xor.sv
